// File: hw/rtl/afc_pkg.sv
`default_nettype none

package afc_pkg;

  localparam int PLANE_COUNT  = 6;
  localparam int FRAC_BITS    = 16;
  localparam int CORNER_COUNT = 8;

  localparam int CoordW    = 32;
  localparam int SlotW     = 3;
  localparam int PlaneAw   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int CornerAw  = $clog2(CORNER_COUNT);
  localparam int ProdW     = 2 * CoordW;
  localparam int SumW      = ProdW + 1;
  localparam int TotW      = SumW + 1;
  localparam int FaceCount = 6;
  localparam int ReasonW   = 4;

  // Reads sweep all CORNER_COUNT slots; LastCnt leaves room for the plane pipeline to drain.
  localparam int SweepLen  = CORNER_COUNT;
  localparam int CntW      = 4;
  localparam int LastCnt   = SweepLen + 3;

  localparam logic [ReasonW-1:0] ReasonNone     = 4'd0;
  localparam int                 ReasonFaceBase = 7;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  typedef struct packed {
    coord_t d;
    coord_t c;
    coord_t b;
    coord_t a;
  } plane_t;

  typedef struct packed {
    logic             clr;
    logic             rd_en;
    logic [SlotW-1:0] rd_idx;
  } sweep_t;

  typedef enum logic [1:0] {
    OP_LOAD_PLANE  = 2'd0,
    OP_LOAD_CORNER = 2'd1,
    OP_TEST        = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

endpackage

`default_nettype wire

// File: hw/rtl/afc_plane_unit.sv
`default_nettype none

module afc_plane_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [afc_pkg::SlotW-1:0]   wr_idx_i,
  input  wire afc_pkg::plane_t             wr_data_i,
  input  wire afc_pkg::sweep_t             sweep_i,
  input  wire afc_pkg::vec3_t              lo_i,
  input  wire afc_pkg::vec3_t              hi_i,
  output logic [afc_pkg::PLANE_COUNT-1:0]  neg_mask_o,
  output logic                             busy_o
);
  import afc_pkg::*;

  plane_t mem [PLANE_COUNT];

  logic               wr_ok;
  logic               rd_ok;
  plane_t             rdata_q;
  logic               v1_q, v2_q, v3_q;
  logic [PlaneAw-1:0] idx1_q, idx2_q, idx3_q;

  logic signed [ProdW-1:0] prod_d [6];
  logic signed [ProdW-1:0] prod_q [6];
  coord_t                  d2_q;

  logic signed [ProdW-1:0] mx_a, mx_b, mx_c;
  logic signed [SumW-1:0]  d_ext, d_scaled;
  logic signed [SumW-1:0]  sab_d, scd_d, sab_q, scd_q;
  logic signed [TotW-1:0]  total;

  logic [PLANE_COUNT-1:0]  neg_mask_q;

  assign wr_ok = wr_en_i && ({1'b0, wr_idx_i} < (SlotW + 1)'(PLANE_COUNT));
  assign rd_ok = sweep_i.rd_en && ({1'b0, sweep_i.rd_idx} < (SlotW + 1)'(PLANE_COUNT));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_idx_i[PlaneAw-1:0]] <= wr_data_i;
    end
    if (rd_ok) begin
      rdata_q <= mem[sweep_i.rd_idx[PlaneAw-1:0]];
    end
  end

  // Each corner coordinate is either the box min or max, so the largest plane
  // value over the eight corners is the sum of the larger product per axis.
  // All eight corners are below the plane exactly when that maximum is.
  always_comb begin
    prod_d[0] = rdata_q.a * lo_i.x;
    prod_d[1] = rdata_q.a * hi_i.x;
    prod_d[2] = rdata_q.b * lo_i.y;
    prod_d[3] = rdata_q.b * hi_i.y;
    prod_d[4] = rdata_q.c * lo_i.z;
    prod_d[5] = rdata_q.c * hi_i.z;
  end

  always_comb begin
    mx_a     = (prod_q[0] > prod_q[1]) ? prod_q[0] : prod_q[1];
    mx_b     = (prod_q[2] > prod_q[3]) ? prod_q[2] : prod_q[3];
    mx_c     = (prod_q[4] > prod_q[5]) ? prod_q[4] : prod_q[5];
    d_ext    = SumW'(d2_q);
    d_scaled = d_ext <<< FRAC_BITS;
    sab_d    = SumW'(mx_a) + SumW'(mx_b);
    scd_d    = SumW'(mx_c) + d_scaled;
    total    = TotW'(sab_q) + TotW'(scd_q);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      prod_q[i] <= prod_d[i];
    end
    d2_q  <= rdata_q.d;
    sab_q <= sab_d;
    scd_q <= scd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      idx1_q     <= '0;
      idx2_q     <= '0;
      idx3_q     <= '0;
      neg_mask_q <= '0;
    end else begin
      v1_q   <= rd_ok;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      idx1_q <= sweep_i.rd_idx[PlaneAw-1:0];
      idx2_q <= idx1_q;
      idx3_q <= idx2_q;
      if (sweep_i.clr) begin
        neg_mask_q <= '0;
      end else if (v3_q && total[TotW-1]) begin
        neg_mask_q[idx3_q] <= 1'b1;
      end
    end
  end

  assign neg_mask_o = neg_mask_q;
  assign busy_o     = v1_q || v2_q || v3_q;

endmodule

`default_nettype wire

// File: hw/rtl/afc_corner_unit.sv
`default_nettype none

module afc_corner_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [afc_pkg::SlotW-1:0]    wr_idx_i,
  input  wire afc_pkg::vec3_t               wr_data_i,
  input  wire afc_pkg::sweep_t              sweep_i,
  input  wire afc_pkg::vec3_t               lo_i,
  input  wire afc_pkg::vec3_t               hi_i,
  output logic [afc_pkg::FaceCount-1:0]     face_o,
  output logic                              busy_o
);
  import afc_pkg::*;

  vec3_t mem [CORNER_COUNT];

  vec3_t                rdata_q;
  logic                 v1_q;
  logic [FaceCount-1:0] beyond;
  logic [FaceCount-1:0] face_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i[CornerAw-1:0]] <= wr_data_i;
    end
    if (sweep_i.rd_en) begin
      rdata_q <= mem[sweep_i.rd_idx[CornerAw-1:0]];
    end
  end

  // Face order: x above max, x below min, then the same for y and z.
  always_comb begin
    beyond[0] = rdata_q.x > hi_i.x;
    beyond[1] = rdata_q.x < lo_i.x;
    beyond[2] = rdata_q.y > hi_i.y;
    beyond[3] = rdata_q.y < lo_i.y;
    beyond[4] = rdata_q.z > hi_i.z;
    beyond[5] = rdata_q.z < lo_i.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      face_q <= '1;
    end else begin
      v1_q <= sweep_i.rd_en;
      if (sweep_i.clr) begin
        face_q <= '1;
      end else if (v1_q) begin
        face_q <= face_q & beyond;
      end
    end
  end

  assign face_o = face_q;
  assign busy_o = v1_q;

endmodule

`default_nettype wire

// File: hw/rtl/aabb_frustum_cull_test_core.sv
`default_nettype none

// Box-against-frustum culling test. Plane and frustum-corner loads are written
// straight into their memories (plane slots from PLANE_COUNT up are dropped)
// and answered with an acknowledgement through the output register. A box test
// captures the box at the accepting edge, then reads sweep the eight-entry
// corner memory and the plane memory side by side, the plane pipeline (memory
// read, six products, pairwise maximum and partial sums, final sum and sign)
// drains, and the result goes to the output register, or waits in a hold state
// while that register is full. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
module aabb_frustum_cull_test_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [afc_pkg::SlotW-1:0]     slot_i,
  input  wire logic signed [31:0]            lo_x_i,
  input  wire logic signed [31:0]            lo_y_i,
  input  wire logic signed [31:0]            lo_z_i,
  input  wire logic signed [31:0]            plane_offset_i,
  input  wire logic signed [31:0]            hi_x_i,
  input  wire logic signed [31:0]            hi_y_i,
  input  wire logic signed [31:0]            hi_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               is_test_o,
  output logic                               visible_o,
  output logic [afc_pkg::ReasonW-1:0]        reject_reason_o
);
  import afc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  vec3_t              lo_q, hi_q;
  logic               out_valid_q, out_is_test_q, out_visible_q;
  logic [ReasonW-1:0] out_reason_q;
  logic               res_is_test_q;
  logic [ReasonW-1:0] res_reason_q;

  logic                   in_acc;
  logic                   is_test_req;
  logic                   out_free;
  logic                   out_load;
  logic                   finish;
  sweep_t                 sweep;
  vec3_t                  in_lo, in_hi;
  plane_t                 plane_wr;
  logic [PLANE_COUNT-1:0] neg_mask;
  logic [FaceCount-1:0]   face;
  logic                   pl_busy, cn_busy;
  logic                   found;
  logic [ReasonW-1:0]     reason;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_test_req = (op_i == OP_TEST);
  assign out_free    = !out_valid_q || out_ready_i;
  assign finish      = (state_q == ST_RUN) && (cnt_q == CntW'(LastCnt));
  assign out_load    = out_free && ((in_acc && !is_test_req) || finish ||
                                    (state_q == ST_HOLD));

  assign in_lo    = '{z: lo_z_i, y: lo_y_i, x: lo_x_i};
  assign in_hi    = '{z: hi_z_i, y: hi_y_i, x: hi_x_i};
  assign plane_wr = '{d: plane_offset_i, c: lo_z_i, b: lo_y_i, a: lo_x_i};

  always_comb begin
    sweep.clr    = in_acc && is_test_req;
    sweep.rd_en  = (state_q == ST_RUN) && (cnt_q < CntW'(SweepLen));
    sweep.rd_idx = cnt_q[SlotW-1:0];
  end

  afc_plane_unit u_plane (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_acc && (op_i == OP_LOAD_PLANE)),
    .wr_idx_i   (slot_i),
    .wr_data_i  (plane_wr),
    .sweep_i    (sweep),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .neg_mask_o (neg_mask),
    .busy_o     (pl_busy)
  );

  afc_corner_unit u_corner (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && (op_i == OP_LOAD_CORNER)),
    .wr_idx_i  (slot_i),
    .wr_data_i (in_lo),
    .sweep_i   (sweep),
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .face_o    (face),
    .busy_o    (cn_busy)
  );

  // The first rejecting plane wins over any face test.
  always_comb begin
    found  = 1'b0;
    reason = ReasonNone;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (!found && neg_mask[p]) begin
        reason = ReasonW'(p + 1);
        found  = 1'b1;
      end
    end
    for (int f = 0; f < FaceCount; f++) begin
      if (!found && face[f]) begin
        reason = ReasonW'(ReasonFaceBase + f);
        found  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      out_valid_q   <= 1'b0;
      out_is_test_q <= 1'b0;
      out_visible_q <= 1'b0;
      out_reason_q  <= ReasonNone;
      res_is_test_q <= 1'b0;
      res_reason_q  <= ReasonNone;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_test_req) begin
              lo_q    <= in_lo;
              hi_q    <= in_hi;
              cnt_q   <= '0;
              state_q <= ST_RUN;
            end else if (out_free) begin
              out_valid_q   <= 1'b1;
              out_is_test_q <= 1'b0;
              out_visible_q <= 1'b0;
              out_reason_q  <= ReasonNone;
            end else begin
              res_is_test_q <= 1'b0;
              res_reason_q  <= ReasonNone;
              state_q       <= ST_HOLD;
            end
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (finish) begin
            if (out_free) begin
              out_valid_q   <= 1'b1;
              out_is_test_q <= 1'b1;
              out_visible_q <= (reason == ReasonNone);
              out_reason_q  <= reason;
              state_q       <= ST_IDLE;
            end else begin
              res_is_test_q <= 1'b1;
              res_reason_q  <= reason;
              state_q       <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_is_test_q <= res_is_test_q;
            out_visible_q <= res_is_test_q && (res_reason_q == ReasonNone);
            out_reason_q  <= res_reason_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_test_o       = out_is_test_q;
  assign visible_o       = out_visible_q;
  assign reject_reason_o = out_reason_q;

  a_drained_at_finish: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    finish |-> !pl_busy && !cn_busy
  ) else $error("result taken while a unit pipeline still holds data");

  a_hold_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q
  ) else $error("result parked although the output register is free");

  a_test_starts_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_test_req) |=> (state_q == ST_RUN) && (cnt_q == '0)
  ) else $error("box test did not start a sweep");

  a_ack_is_clean: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_is_test_q) |-> !out_visible_q && (out_reason_q == ReasonNone)
  ) else $error("load acknowledgement carries test fields");

  a_visible_matches_reason: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_is_test_q) |-> (out_visible_q == (out_reason_q == ReasonNone))
  ) else $error("visible flag disagrees with reject reason");

endmodule

`default_nettype wire
